>>> hdl/lru_key_value_cache_core_defines.svh
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LRU cache assertion failed");
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LRU cache assertion failed");
`else
`define LKVC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/lkvc_pkg.sv
// Types and constants of the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 16;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift_all;
        logic shift_valid;
        logic shift_hit;
    } ctrl_t;

endpackage

>>> hdl/lkvc_cell.sv
// One position of the recency-ordered entry chain, with key compare and shift.
module lkvc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lkvc_pkg::KEY_W-1:0]  key_in,
    input  lkvc_pkg::ctrl_t             ctrl,
    input  lkvc_pkg::entry_t            prev,
    input  logic                        match_in,
    input  logic [lkvc_pkg::DATA_W-1:0] data_in,
    output lkvc_pkg::entry_t            entry,
    output logic                        match_out,
    output logic [lkvc_pkg::DATA_W-1:0] data_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [lkvc_pkg::KEY_W-1:0]  key_reg;
    logic [lkvc_pkg::KEY_W-1:0]  key_next;
    logic [lkvc_pkg::DATA_W-1:0] data_reg;
    logic [lkvc_pkg::DATA_W-1:0] data_next;
    logic                        my_match;
    logic                        shift;

    assign my_match  = valid_reg && (key_reg == key_in);
    assign match_out = my_match || match_in;
    assign data_out  = my_match ? data_reg : data_in;

    // The cell takes its neighbor's entry when it lies at or above the slot being freed.
    assign shift = ctrl.load && (ctrl.shift_all
                                 || (ctrl.shift_valid && valid_reg)
                                 || (ctrl.shift_hit && match_out));

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        if (shift) begin
            valid_next = prev.valid;
            key_next   = prev.key;
            data_next  = prev.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign entry = '{valid: valid_reg, key: key_reg, data: data_reg};

endmodule

>>> hdl/lru_key_value_cache_core.sv
// LRU key-value cache: a chain of cells kept in recency order, head most recent.
// Output: the result word is registered and appears in the cycle after the request word is accepted.
// Throughput: one request per cycle while the output is drained; the compare and the chain shift finish in that cycle.
// Reset (synchronous, aresetn low): all entries invalid, occupancy zero, capacity 16.
// Output stall: a new request is taken whenever the output register is empty or drained.
`include "lru_key_value_cache_core_defines.svh"
module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_capacity,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [lkvc_pkg::KEY_W-1:0]  s_key,
    input  logic [lkvc_pkg::DATA_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [lkvc_pkg::DATA_W-1:0] m_read_value
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::CAP_W-1:0]  cap_reg;
    logic [OCC_W-1:0]            occ_reg;
    logic [OCC_W-1:0]            occ_next;
    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic [lkvc_pkg::DATA_W-1:0] m_read_value_reg;

    logic                        accept;
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] hit_data;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            cap_eff;
    logic                        has_room;
    lkvc_pkg::ctrl_t             ctrl;
    lkvc_pkg::entry_t            head_in;

    lkvc_pkg::entry_t            entries [ENTRIES+1];
    logic [ENTRIES:0]            match_chain;
    logic [lkvc_pkg::DATA_W-1:0] data_chain [ENTRIES+1];
    logic [ENTRIES-1:0]          valid_vec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign entries[0]           = head_in;
    assign match_chain[ENTRIES] = 1'b0;
    assign data_chain[ENTRIES]  = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lkvc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key_in    (s_key),
            .ctrl      (ctrl),
            .prev      (entries[i]),
            .match_in  (match_chain[i+1]),
            .data_in   (data_chain[i+1]),
            .entry     (entries[i+1]),
            .match_out (match_chain[i]),
            .data_out  (data_chain[i])
        );
        assign valid_vec[i] = entries[i+1].valid;
    end

    assign hit      = match_chain[0];
    assign hit_data = data_chain[0];

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign has_room = CMP_W'(occ_reg) < cap_eff;

    always_comb begin
        ctrl     = '0;
        occ_next = occ_reg;
        head_in  = '{valid: 1'b1, key: s_key, data: s_value};
        if (accept) begin
            if (hit) begin
                ctrl.load      = 1'b1;
                ctrl.shift_hit = 1'b1;
                if (s_action == lkvc_pkg::ACT_GET) begin
                    head_in.data = hit_data;
                end
            end else if (s_action == lkvc_pkg::ACT_PUT) begin
                ctrl.load = 1'b1;
                if (has_room) begin
                    ctrl.shift_all = 1'b1;
                    occ_next       = occ_reg + OCC_W'(1);
                end else begin
                    ctrl.shift_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= lkvc_pkg::CAP_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_capacity;
            end
            occ_reg <= occ_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_hit_reg        <= hit;
            m_read_value_reg <= (hit && s_action == lkvc_pkg::ACT_GET) ? hit_data : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

    `LKVC_ASSERT_NOW(a_occ_count, aclk, aresetn, 1'b1, $countones(valid_vec) == occ_reg)
    `LKVC_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1, ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    `LKVC_ASSERT_NOW(a_occ_max, aclk, aresetn, 1'b1, occ_reg <= OCC_W'(ENTRIES))
    `LKVC_ASSERT_NEXT(a_put_head, aclk, aresetn, accept && s_action == lkvc_pkg::ACT_PUT, valid_vec[0] && entries[1].key == $past(s_key))

endmodule
